/* hdl/adc_oversample_channel_scanner_macros.svh */
// Assertion macros used by the scan core.
`ifndef ADC_OVERSAMPLE_CHANNEL_SCANNER_MACROS_SVH
`define ADC_OVERSAMPLE_CHANNEL_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AOCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AOCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/aocs_pkg.sv */
// Types, constants and helper functions of the ADC channel scanner.
package aocs_pkg;

  // Build-time sizing of the scanner.
  localparam int CHANNELS     = 8;
  localparam int SAMPLE_SHIFT = 4;
  localparam int SAMPLE_BITS  = 10;

  // Fixed field and register widths.
  localparam int MUX_SLOTS   = 8;
  localparam int MUX_W       = 5;
  localparam int VALUE_W     = 10;
  localparam int SAMPLE_IN_W = 10;
  localparam int RCH_W       = 3;
  localparam int CNT_CFG_W   = 4;
  localparam int CFG_DATA_W  = MUX_SLOTS * MUX_W;
  localparam int CFG_IDX_W   = 1;

  // Derived sizes.
  localparam int BLOCK_LEN = 1 << SAMPLE_SHIFT;
  localparam int SUM_W     = SAMPLE_BITS + SAMPLE_SHIFT;
  localparam int SCNT_W    = $clog2(BLOCK_LEN + 1);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ACT_MAX   = (CHANNELS < MUX_SLOTS) ? CHANNELS : MUX_SLOTS;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUX_CODES     = 1'b1;

  typedef enum logic [0:0] {
    OP_CONVERT = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  // One input item.
  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_IN_W-1:0] sample;
    logic [RCH_W-1:0]       read_channel;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [MUX_W-1:0]   mux_select;
    logic               average_stored;
    logic [VALUE_W-1:0] read_value;
  } result_t;

  // Number of channels in the scan: zero counts as one, capped at the slot count.
  function automatic logic [CNT_CFG_W-1:0] active_count(input logic [CNT_CFG_W-1:0] n);
    logic [CNT_CFG_W-1:0] r;
    r = n;
    if (r == '0) r = CNT_CFG_W'(1);
    if (32'(r) > ACT_MAX) r = CNT_CFG_W'(ACT_MAX);
    return r;
  endfunction

  // Mux code of a channel; channels past the packed slots give zero.
  function automatic logic [MUX_W-1:0] mux_of(input logic [CFG_DATA_W-1:0] codes,
                                               input logic [CH_W-1:0] ch);
    logic [MUX_W-1:0] r;
    r = '0;
    for (int i = 0; i < MUX_SLOTS; i++) begin
      if (32'(ch) == i) r = codes[i*MUX_W +: MUX_W];
    end
    return r;
  endfunction

endpackage

/* hdl/aocs_scan_core.sv */
// Configuration registers, scan state, accumulator, average store and the per-item result logic.
`include "adc_oversample_channel_scanner_macros.svh"

module aocs_scan_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aocs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aocs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              commit,
  input  aocs_pkg::item_t                   item,
  output aocs_pkg::result_t                 result
);
  import aocs_pkg::*;

  logic [CNT_CFG_W-1:0]   chan_cnt_r;
  logic [CFG_DATA_W-1:0]  mux_codes_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CH_W-1:0]        cur_r, cur_nxt;
  logic [SAMPLE_BITS-1:0] avg_r [CHANNELS];

  logic [SAMPLE_BITS-1:0] smp;
  logic [CH_W-1:0]        rd_idx;
  logic                   rd_in_range;
  logic                   store_en;
  logic [CNT_CFG_W-1:0]   active;

  assign smp         = SAMPLE_BITS'(item.sample);
  assign rd_idx      = CH_W'(item.read_channel);
  assign rd_in_range = 32'(item.read_channel) < CHANNELS;
  assign active      = active_count(chan_cnt_r);

  // Next state and result for the item in the input register.
  always_comb begin
    sum_nxt               = sum_r;
    cnt_nxt               = cnt_r;
    cur_nxt               = cur_r;
    store_en              = 1'b0;
    result.average_stored = 1'b0;
    result.read_value     = '0;
    if (item.op == OP_READ) begin
      if (rd_in_range) result.read_value = VALUE_W'(avg_r[rd_idx]);
    end else if (32'(cnt_r) < BLOCK_LEN) begin
      cnt_nxt = cnt_r + SCNT_W'(1);
      sum_nxt = SUM_W'(sum_r + SUM_W'(smp));
    end else begin
      // Block closed: this sample is dropped and the average is stored.
      store_en              = 1'b1;
      sum_nxt               = '0;
      cnt_nxt               = '0;
      cur_nxt               = ((32'(cur_r) + 32'd1) >= 32'(active)) ? '0
                                                                     : cur_r + CH_W'(1);
      result.average_stored = 1'b1;
    end
    result.mux_select = mux_of(mux_codes_r, cur_nxt);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r  <= CNT_CFG_W'(1);
      mux_codes_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: chan_cnt_r  <= cfg_data[CNT_CFG_W-1:0];
        CFG_MUX_CODES:     mux_codes_r <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Accumulator and scan position, updated when an item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      cur_r <= '0;
    end else if (commit) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
    end
  end

  // Average store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) avg_r[i] <= '0;
    end else if (commit && store_en && (32'(cur_r) < CHANNELS)) begin
      avg_r[cur_r] <= SAMPLE_BITS'(sum_r >> SAMPLE_SHIFT);
    end
  end

  `AOCS_ASSERT_NEXT(a_close_clears, clk, rst_n, commit && store_en, (cnt_r == '0) && (sum_r == '0), "closing a block must clear count and sum")
  `AOCS_ASSERT_NEXT(a_read_keeps_state, clk, rst_n, commit && (item.op == OP_READ), $stable(sum_r) && $stable(cnt_r) && $stable(cur_r), "a read must not change scan state")
  `AOCS_ASSERT_NEXT(a_chan_in_scan, clk, rst_n, commit && store_en, 32'(cur_r) < 32'(active), "scan channel beyond active count")
  `AOCS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, 32'(cnt_r) <= BLOCK_LEN, "sample count beyond block length")

endmodule

/* hdl/adc_oversample_channel_scanner.sv */
// Top level of the round-robin ADC channel scanner with oversampling average.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | operation, sample, read_channel
//   out_    | output    | out_valid/out_stall | mux_select, average_stored, read_value
//   cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall stays low.
// The item passes an input register, the scan logic and a result register.
// Reset (rst_n low, synchronous) empties both registers and clears the averages.
// A stalled result holds; the input register can still take one item while the
// result waits, and in_stall then stays high until the result is taken.
module adc_oversample_channel_scanner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [0:0]                        in_operation,
  input  logic [aocs_pkg::SAMPLE_IN_W-1:0]  in_sample,
  input  logic [aocs_pkg::RCH_W-1:0]        in_read_channel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [aocs_pkg::MUX_W-1:0]        out_mux_select,
  output logic                              out_average_stored,
  output logic [aocs_pkg::VALUE_W-1:0]      out_read_value,
  input  logic                              cfg_we,
  input  logic [aocs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aocs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aocs_pkg::*;

  item_t   item_r;
  logic    item_valid_r;
  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    out_free;
  logic    commit;
  logic    in_acc;

  // The result register can load when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = item_valid_r && out_free;
  assign in_stall = item_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_acc) begin
      item_valid_r <= 1'b1;
    end else if (commit) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.op           <= op_t'(in_operation);
      item_r.sample       <= in_sample;
      item_r.read_channel <= in_read_channel;
    end
  end

  aocs_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .commit    (commit),
    .item      (item_r),
    .result    (res_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mux_select     = res_r.mux_select;
  assign out_average_stored = res_r.average_stored;
  assign out_read_value     = res_r.read_value;

endmodule

/* dv/adc_oversample_channel_scanner_tb.sv */
// Self-checking testbench for the round-robin ADC channel scanner with oversampling average.
module adc_oversample_channel_scanner_tb;
  import aocs_pkg::*;

  typedef enum int {
    STYLE_RANDOM,
    STYLE_FULL,
    STYLE_ZERO,
    STYLE_STEADY
  } sample_style_t;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_RUNS
  } stall_mode_t;

  localparam int CONV_PER_BLOCK = BLOCK_LEN + 1;
  localparam int PHASES = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [0:0] in_operation = '0;
  logic [SAMPLE_IN_W-1:0] in_sample = '0;
  logic [RCH_W-1:0] in_read_channel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MUX_W-1:0] out_mux_select;
  logic out_average_stored;
  logic [VALUE_W-1:0] out_read_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adc_oversample_channel_scanner dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_sample(in_sample),
    .in_read_channel(in_read_channel),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_mux_select(out_mux_select),
    .out_average_stored(out_average_stored),
    .out_read_value(out_read_value),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Scanner state as the testbench sees it, plus its copy of the registers.
  logic [VALUE_W-1:0] avg_store [CHANNELS];
  logic [SUM_W-1:0] acc_sum = '0;
  logic [SCNT_W-1:0] acc_count = '0;
  logic [CH_W-1:0] scan_ch = '0;
  logic [CNT_CFG_W-1:0] count_reg = CNT_CFG_W'(1);
  logic [CFG_DATA_W-1:0] mux_reg = '0;

  item_t pending_items [$];
  result_t expected_results [$];
  int unsigned offered_count = 0;
  int unsigned taken_count = 0;
  int error_count = 0;

  // Driver and stall generator state.
  item_t drive_item;
  int burst_left = 0;
  int gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_timer = 0;
  int stall_tick = 0;
  int run_left = 0;
  logic run_on = 1'b0;

  initial begin
    for (int i = 0; i < CHANNELS; i++) avg_store[i] = '0;
  end

  initial begin
    forever #2 clk = ~clk;
  end

  // One line per failure, and every failure is counted.
  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Works out the result of one accepted item and advances the scan state.
  function automatic result_t scan_step(input item_t itm);
    result_t r;
    int active;
    r = '0;
    if (itm.op == OP_READ) begin
      r.read_value = avg_store[itm.read_channel];
    end else if (int'(acc_count) < BLOCK_LEN) begin
      acc_count = acc_count + SCNT_W'(1);
      acc_sum = acc_sum + SUM_W'(itm.sample);
    end else begin
      // The sample after a full block is dropped; the block's average is stored.
      avg_store[scan_ch] = VALUE_W'(acc_sum >> SAMPLE_SHIFT);
      acc_sum = '0;
      acc_count = '0;
      active = int'(count_reg);
      if (active == 0) active = 1;
      if (active > ACT_MAX) active = ACT_MAX;
      // A count lowered below the current channel also wraps to channel 0.
      if (int'(scan_ch) + 1 >= active) scan_ch = '0;
      else scan_ch = scan_ch + CH_W'(1);
      r.average_stored = 1'b1;
    end
    r.mux_select = mux_reg[int'(scan_ch) * MUX_W +: MUX_W];
    return r;
  endfunction

  // Sender: bursts of items with random gaps; an offered item holds until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (taken_count == offered_count) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_operation <= drive_item.op;
        in_sample <= drive_item.sample;
        in_read_channel <= drive_item.read_channel;
        offered_count++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches among several modes over time.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_timer = $urandom_range(20, 120);
    end else begin
      stall_timer--;
    end
    stall_tick++;
    if (run_left == 0) begin
      run_on = ~run_on;
      run_left = run_on ? $urandom_range(3, 16) : $urandom_range(1, 5);
    end else begin
      run_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: out_stall <= ((stall_tick % 5) < 2);
      default: out_stall <= run_on;
    endcase
  end

  // Monitor: checks each taken result, then predicts for each taken item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_error("result arrived with no item outstanding");
        end else begin
          if (out_mux_select !== expected_results[0].mux_select)
            report_error($sformatf("mux_select: expected %0d, got %0d",
                                   expected_results[0].mux_select, out_mux_select));
          if (out_average_stored !== expected_results[0].average_stored)
            report_error($sformatf("average_stored: expected %0d, got %0d",
                                   expected_results[0].average_stored, out_average_stored));
          if (out_read_value !== expected_results[0].read_value)
            report_error($sformatf("read_value: expected %0d, got %0d",
                                   expected_results[0].read_value, out_read_value));
          void'(expected_results.pop_front());
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(scan_step(item_t'({in_operation, in_sample,
                                                       in_read_channel})));
        taken_count++;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == CFG_CHANNEL_COUNT) count_reg = data[CNT_CFG_W-1:0];
    else mux_reg = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_item(input op_t op, input int smp, input int ch);
    item_t itm;
    itm.op = op;
    itm.sample = SAMPLE_IN_W'(smp);
    itm.read_channel = RCH_W'(ch);
    pending_items.push_back(itm);
  endtask

  // Waits until every item has been taken and every result checked.
  task automatic wait_drained();
    while (pending_items.size() != 0 || taken_count != offered_count ||
           expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Mostly runs of conversions in block-sized groups with reads mixed in, plus noise.
  task automatic queue_random_phase(input int n);
    sample_style_t style;
    int conv_left;
    int pick;
    int steady;
    item_t itm;
    conv_left = 0;
    style = STYLE_RANDOM;
    steady = 0;
    for (int i = 0; i < n; i++) begin
      if (conv_left == 0) begin
        style = sample_style_t'($urandom_range(0, 3));
        steady = $urandom_range(0, 1023);
        conv_left = CONV_PER_BLOCK;
      end
      pick = $urandom_range(0, 99);
      itm.op = OP_CONVERT;
      itm.sample = SAMPLE_IN_W'($urandom_range(0, 1023));
      itm.read_channel = RCH_W'($urandom_range(0, 7));
      if (pick < 8) begin
        itm.op = op_t'($urandom_range(0, 1));
      end else if (pick < 22) begin
        itm.op = OP_READ;
      end else begin
        case (style)
          STYLE_FULL: itm.sample = '1;
          STYLE_ZERO: itm.sample = '0;
          STYLE_STEADY: itm.sample = SAMPLE_IN_W'(steady ^ $urandom_range(0, 3));
          default: ;
        endcase
        conv_left--;
      end
      pending_items.push_back(itm);
    end
  endtask

  // Channel counts per phase: extremes, zero, over-range, and drops below the scan position.
  int count_plan [PHASES] = '{8, 0, 15, 3, 2, 8, 1, 9, 5, 4, 7, 6};

  initial begin
    logic [CFG_DATA_W-1:0] codes;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items: reads of the cleared store, a full-scale block, and a zero sample.
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(2));
    write_reg(CFG_MUX_CODES, 40'h5A_C3_96_E1_7F);
    @(posedge clk);
    push_item(OP_READ, 1023, 0);
    push_item(OP_READ, 0, 7);
    for (int i = 0; i < BLOCK_LEN; i++) push_item(OP_CONVERT, 1023, 7);
    push_item(OP_CONVERT, 'h155, 0);
    push_item(OP_READ, 0, 0);
    push_item(OP_READ, 0, 1);
    push_item(OP_CONVERT, 0, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) codes = '1;
      else if (p == 1) codes = '0;
      else codes = CFG_DATA_W'({$urandom(), $urandom()});
      write_reg(CFG_CHANNEL_COUNT,
                {(CFG_DATA_W-CNT_CFG_W)'({$urandom(), $urandom()}),
                 CNT_CFG_W'(count_plan[p])});
      write_reg(CFG_MUX_CODES, codes);
      @(posedge clk);
      queue_random_phase($urandom_range(35, 65));
      wait_drained();
    end

    // Let the pipeline show any stray result before the verdict.
    repeat (6) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit well above the slowest expected run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
